/* src/lbps_pkg.sv */
// shared types, codes and the blink pattern table for the led blink sequencer
package lbps_pkg;

    localparam int unsigned TICK_W     = 16;
    localparam int unsigned TABLE_W    = 32;
    localparam int unsigned TABLE_SIZE = 12;
    localparam int unsigned SEL_W      = 2;
    localparam int unsigned PSEL_W     = 4;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned SHOWN_LEDS = 3;

    // request function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREVER_CODE = 1'b1;

    localparam logic [TICK_W-1:0] DISABLE_CODE_RST = 16'h0000;
    localparam logic [TICK_W-1:0] FOREVER_CODE_RST = 16'hFFFF;

    // control shared by all led channels for one request
    typedef struct packed {
        logic              tick;
        logic              enable;
        logic              endless;
        logic [TICK_W-1:0] ticks;
    } lbps_ctrl_t;

    // blink pattern table, bit 0 is shown first; indexes past the table are off
    function automatic logic [TABLE_W-1:0] blink_word(input logic [PSEL_W-1:0] sel);
        logic [TABLE_W-1:0] w;
        begin
            case (sel)
                4'd0:    w = 32'h0000_0000;
                4'd1:    w = 32'hFFFF_FFFF;
                4'd2:    w = 32'h0000_0001;
                4'd3:    w = 32'h8000_8000;
                4'd4:    w = 32'h8100_8080;
                4'd5:    w = 32'hFFFF_0000;
                4'd6:    w = 32'hF0F0_F0F0;
                4'd7:    w = 32'hCCCC_CCCC;
                4'd8:    w = 32'h9273_9C92;
                4'd9:    w = 32'hAAAA_AAAA;
                4'd10:   w = 32'h9249_2492;
                4'd11:   w = 32'h8888_8888;
                default: w = 32'h0000_0000;
            endcase
            return w;
        end
    endfunction

endpackage

/* src/led_blink_pattern_sequencer_unit.sv */
// top level of the led blink pattern sequencer
//
// requests arrive on in_valid/in_ready. func selects a tick (step every
// enabled led one pattern position) or a load (give one led a pattern,
// a tick budget and its enabled/endless flags from the two code registers).
// every request yields exactly one result on out_valid/out_ready carrying
// red_level, green_level and blue_level as they stand after that request.
// the result is registered and valid the cycle after acceptance.
// throughput is one request per cycle; all per-led work is a compare and a
// decrement feeding the level registers, which double as the result register.
// when the receiver stalls, in_ready drops until the pending result is taken;
// a new request is accepted in the same cycle the old result leaves.
// configuration writes on cfg_valid/cfg_ready (cfg_index, cfg_data) are
// always taken and should only be issued while no result is pending.
// reset clears all levels, flags and the pattern position, sets the disable
// code to zero and the forever code to all ones, and leaves no result pending.
module led_blink_pattern_sequencer_unit
    import lbps_pkg::*;
#(
    parameter int unsigned LED_COUNT    = 3,
    parameter int unsigned PATTERN_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [SEL_W-1:0]     led_select,
    input  logic [PSEL_W-1:0]    pattern_select,
    input  logic [TICK_W-1:0]    tick_count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 red_level,
    output logic                 green_level,
    output logic                 blue_level
);

    localparam int unsigned POS_W = $clog2(PATTERN_BITS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PATTERN_BITS - 1);

    logic [TICK_W-1:0]       disable_code_reg, disable_code_next;
    logic [TICK_W-1:0]       forever_code_reg, forever_code_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    accept;
    logic                    is_load;
    lbps_ctrl_t              ctrl;
    logic [PATTERN_BITS-1:0] word;
    logic [LED_COUNT-1:0]    levels;
    logic [SHOWN_LEDS-1:0]   shown;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign is_load   = accept && (func == FUNC_LOAD);

    always_comb
    begin
        disable_code_next = disable_code_reg;
        forever_code_next = forever_code_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DISABLE_CODE: disable_code_next = cfg_data;
                CFG_FOREVER_CODE: forever_code_next = cfg_data;
                default:          disable_code_next = disable_code_reg;
            endcase
        end
    end

    assign ctrl.tick    = accept && (func == FUNC_TICK);
    assign ctrl.enable  = (tick_count != disable_code_reg);
    assign ctrl.endless = (tick_count == forever_code_reg);
    assign ctrl.ticks   = tick_count;

    assign word = PATTERN_BITS'(blink_word(pattern_select));

    always_comb
    begin
        pos_next = pos_reg;
        if (ctrl.tick)
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
    end

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disable_code_reg <= DISABLE_CODE_RST;
            forever_code_reg <= FOREVER_CODE_RST;
            pos_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            disable_code_reg <= disable_code_next;
            forever_code_reg <= forever_code_next;
            pos_reg          <= pos_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < LED_COUNT; i++)
        begin : g_led
            logic hit;
            // only the three addressable leds can be loaded
            if (i < SHOWN_LEDS)
            begin : g_addr
                assign hit = is_load && (led_select == SEL_W'(i));
            end
            else
            begin : g_noaddr
                assign hit = 1'b0;
            end

            lbps_led_channel #(
                .PATTERN_BITS (PATTERN_BITS),
                .POS_W        (POS_W)
            ) u_chan (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .load  (hit),
                .word  (word),
                .pos   (pos_reg),
                .level (levels[i])
            );
        end

        for (i = 0; i < SHOWN_LEDS; i++)
        begin : g_shown
            if (i < LED_COUNT)
            begin : g_on
                assign shown[i] = levels[i];
            end
            else
            begin : g_off
                assign shown[i] = 1'b0;
            end
        end
    endgenerate

    // levels only move on acceptance, so they hold while a result waits
    assign out_valid   = out_valid_reg;
    assign red_level   = shown[0];
    assign green_level = shown[1];
    assign blue_level  = shown[2];

endmodule

/* src/lbps_led_channel.sv */
// one led channel: pattern word, tick budget, flags and drive level
module lbps_led_channel
    import lbps_pkg::*;
#(
    parameter int unsigned PATTERN_BITS = 32,
    parameter int unsigned POS_W        = 5
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lbps_ctrl_t              ctrl,
    input  logic                    load,
    input  logic [PATTERN_BITS-1:0] word,
    input  logic [POS_W-1:0]        pos,
    output logic                    level
);

    logic [PATTERN_BITS-1:0] word_reg, word_next;
    logic [TICK_W-1:0]       ticks_reg, ticks_next;
    logic                    enabled_reg, enabled_next;
    logic                    endless_reg, endless_next;
    logic                    level_reg, level_next;

    always_comb
    begin
        word_next    = word_reg;
        ticks_next   = ticks_reg;
        enabled_next = enabled_reg;
        endless_next = endless_reg;
        level_next   = level_reg;
        if (load)
        begin
            word_next    = word;
            ticks_next   = ctrl.ticks;
            enabled_next = ctrl.enable;
            endless_next = ctrl.endless;
        end
        else if (ctrl.tick && enabled_reg)
        begin
            if ((ticks_reg != '0) || endless_reg)
                level_next = word_reg[pos];
            if (!endless_reg)
            begin
                // budget used up: led goes dark
                if (ticks_reg == '0)
                    level_next = 1'b0;
                else
                    ticks_next = ticks_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg    <= '0;
            ticks_reg   <= '0;
            enabled_reg <= 1'b0;
            endless_reg <= 1'b0;
            level_reg   <= 1'b0;
        end
        else
        begin
            word_reg    <= word_next;
            ticks_reg   <= ticks_next;
            enabled_reg <= enabled_next;
            endless_reg <= endless_next;
            level_reg   <= level_next;
        end
    end

    assign level = level_reg;

endmodule

/* verif/testbench.sv */
// self-checking testbench for the led blink pattern sequencer
`timescale 1ns / 100ps

module testbench;
    import lbps_pkg::*;

    localparam logic [TABLE_W-1:0] BLINK_WORDS [TABLE_SIZE] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_8000,
        32'h8100_8080, 32'hFFFF_0000, 32'hF0F0_F0F0, 32'hCCCC_CCCC,
        32'h9273_9C92, 32'hAAAA_AAAA, 32'h9249_2492, 32'h8888_8888
    };
    localparam int PHASE_ITEMS = 290;

    class blink_scoreboard;
        logic [TICK_W-1:0]  disable_code;
        logic [TICK_W-1:0]  forever_code;
        logic [4:0]         position;
        logic [TABLE_W-1:0] word [SHOWN_LEDS];
        logic [TICK_W-1:0]  ticks_left [SHOWN_LEDS];
        bit                 enabled [SHOWN_LEDS];
        bit                 endless [SHOWN_LEDS];
        bit                 level [SHOWN_LEDS];
        logic [2:0]         expected_levels [$];
        int                 errors;

        function new();
            disable_code = DISABLE_CODE_RST;
            forever_code = FOREVER_CODE_RST;
            position     = '0;
            errors       = 0;
            for (int i = 0; i < SHOWN_LEDS; i++)
            begin
                word[i]       = '0;
                ticks_left[i] = '0;
                enabled[i]    = 1'b0;
                endless[i]    = 1'b0;
                level[i]      = 1'b0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
            if (idx == CFG_DISABLE_CODE)
                disable_code = val;
            else
                forever_code = val;
        endfunction

        // step the led state for one accepted request and queue its levels
        function void note_request(logic f, logic [SEL_W-1:0] sel,
                                   logic [PSEL_W-1:0] pat, logic [TICK_W-1:0] cnt);
            if (f == FUNC_TICK)
            begin
                for (int i = 0; i < SHOWN_LEDS; i++)
                begin
                    if (enabled[i])
                    begin
                        if (ticks_left[i] != 0 || endless[i])
                            level[i] = word[i][position];
                        if (!endless[i])
                        begin
                            if (ticks_left[i] == 0)
                                level[i] = 1'b0;
                            else
                                ticks_left[i] = ticks_left[i] - 1'b1;
                        end
                    end
                end
                position = position + 1'b1;
            end
            else if (sel < SHOWN_LEDS)
            begin
                // indexes past the table select the off pattern
                word[sel]       = (pat < TABLE_SIZE) ? BLINK_WORDS[pat] : '0;
                ticks_left[sel] = cnt;
                enabled[sel]    = (cnt != disable_code);
                endless[sel]    = (cnt == forever_code);
            end
            expected_levels.push_back({level[2], level[1], level[0]});
        endfunction

        function void check_result(logic r, logic g, logic b);
            logic [2:0] exp_lv;
            if (expected_levels.size() == 0)
            begin
                $error("unexpected result: red %0b green %0b blue %0b", r, g, b);
                errors++;
                return;
            end
            exp_lv = expected_levels.pop_front();
            if (r !== exp_lv[0])
            begin
                $error("red_level: expected %0b, got %0b", exp_lv[0], r);
                errors++;
            end
            if (g !== exp_lv[1])
            begin
                $error("green_level: expected %0b, got %0b", exp_lv[1], g);
                errors++;
            end
            if (b !== exp_lv[2])
            begin
                $error("blue_level: expected %0b, got %0b", exp_lv[2], b);
                errors++;
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [TICK_W-1:0]    cfg_data       = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic                 func           = 1'b0;
    logic [SEL_W-1:0]     led_select     = '0;
    logic [PSEL_W-1:0]    pattern_select = '0;
    logic [TICK_W-1:0]    tick_count     = '0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic                 red_level;
    logic                 green_level;
    logic                 blue_level;

    blink_scoreboard sb;
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;

    led_blink_pattern_sequencer_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .led_select     (led_select),
        .pattern_select (pattern_select),
        .tick_count     (tick_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_level      (red_level),
        .green_level    (green_level),
        .blue_level     (blue_level)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) < stall_pct) ? 1'b0 : 1'b1;
        end
    end

    // results are checked before the request taken at the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(red_level, green_level, blue_level);
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_request(func, led_select, pattern_select, tick_count);
        end
    end

    task automatic send_request(input logic f, input logic [SEL_W-1:0] sel,
                                input logic [PSEL_W-1:0] pat, input logic [TICK_W-1:0] cnt);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= f;
        led_select     <= sel;
        pattern_select <= pat;
        tick_count     <= cnt;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop offering requests and wait until every result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        @(posedge clk);
    endtask

    task automatic set_codes(input logic [TICK_W-1:0] dis, input logic [TICK_W-1:0] fev);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DISABLE_CODE;
        cfg_data  <= dis;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_FOREVER_CODE;
        cfg_data  <= fev;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        logic [TICK_W-1:0] cnt;
        int                k;
        k = $urandom_range(0, 99);
        if (k < 30)
            cnt = TICK_W'($urandom_range(0, 40));
        else if (k < 45)
            cnt = sb.disable_code;
        else if (k < 60)
            cnt = sb.forever_code;
        else
            cnt = TICK_W'($urandom);
        // mostly ticks so that loaded budgets run out
        if ($urandom_range(0, 99) < 30)
            send_request(FUNC_LOAD, SEL_W'($urandom_range(0, 3)),
                         PSEL_W'($urandom_range(0, 15)), cnt);
        else
            send_request(FUNC_TICK, SEL_W'($urandom_range(0, 3)),
                         PSEL_W'($urandom_range(0, 15)), TICK_W'($urandom));
    endtask

    initial
    begin
        logic [TICK_W-1:0] dis_codes [6];
        logic [TICK_W-1:0] fev_codes [6];
        dis_codes = '{16'h0000, 16'hFFFF, 16'h0005, 16'h0000, 16'h0000, 16'h0001};
        fev_codes = '{16'hFFFF, 16'h0000, 16'h0005, 16'h0000, 16'h0000, 16'h0002};
        dis_codes[3] = TICK_W'($urandom);
        fev_codes[3] = TICK_W'($urandom);
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset codes
        send_request(FUNC_TICK, 2'd0, 4'd0, 16'h0000);
        send_request(FUNC_LOAD, 2'd0, 4'd1, 16'd3);
        send_request(FUNC_LOAD, 2'd1, 4'd7, 16'hFFFF);
        send_request(FUNC_LOAD, 2'd2, 4'd8, 16'd2);
        // led select three is ignored
        send_request(FUNC_LOAD, 2'd3, 4'd5, 16'd5);
        repeat (5) send_request(FUNC_TICK, 2'd3, 4'd15, 16'hFFFF);
        send_request(FUNC_LOAD, 2'd0, 4'd15, 16'd4);
        send_request(FUNC_LOAD, 2'd2, 4'd12, 16'hFFFF);
        send_request(FUNC_LOAD, 2'd0, 4'd11, 16'd40);
        // count equal to the disable code: led keeps its level
        send_request(FUNC_LOAD, 2'd1, 4'd0, 16'h0000);
        send_request(FUNC_LOAD, 2'd2, 4'd10, 16'hFFFE);
        repeat (4) send_request(FUNC_TICK, 2'd0, 4'd0, 16'h0000);
        send_request(FUNC_LOAD, 2'd1, 4'd9, 16'd1);
        send_request(FUNC_LOAD, 2'd2, 4'd2, 16'hFFFF);
        repeat (3) send_request(FUNC_TICK, 2'd1, 4'd6, 16'h8000);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            set_codes(dis_codes[ph], fev_codes[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == 100)
                    hold_left = 80;
                if (n == 200)
                    drain();
                random_request();
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
